/* hw/rtl/warp_marker_time_mapper_defines.svh */
// Assertion helpers for the warp marker time mapper.
`ifndef WARP_MARKER_TIME_MAPPER_DEFINES_SVH
`define WARP_MARKER_TIME_MAPPER_DEFINES_SVH

// Condition that holds at every clock edge out of reset.
`define WMTM_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Consequent that holds in the cycle after the antecedent.
`define WMTM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/wmtm_pkg.sv */
package wmtm_pkg;

    localparam int TIME_W  = 32;
    localparam int RATIO_W = 20;
    localparam int CMD_W   = 2;
    localparam int STAT_W  = 2;
    localparam int CFG_IDX_W = 2;

    localparam int MAX_MARKERS_DEF = 16;

    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FWD   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_INV   = 2'd3;

    localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL = 2'd1;
    localparam logic [STAT_W-1:0] STAT_SAT  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_CLIP   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRCLEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RATIO  = 2'd2;

    localparam logic [RATIO_W-1:0] RATIO_RESET   = 20'd65536;
    localparam logic [RATIO_W-1:0] MIN_DIV_RATIO = 20'd7;
    localparam logic [TIME_W-1:0]  ALL_ONES      = '1;

    // One map point: timeline and source time.
    typedef struct packed {
        logic [TIME_W-1:0] tline;
        logic [TIME_W-1:0] stime;
    } point_t;

endpackage

/* hw/rtl/warp_marker_time_mapper.sv */
// Warp marker time mapper. Maps Q16.16 clip timeline time to source time
// (cmd 2) and back (cmd 3) through a piecewise linear map made of the
// origin, the stored warp markers and the clip end point; cmd 0 clears the
// markers and cmd 1 adds one. Markers live in one synchronous RAM kept
// sorted by timeline; a marker that could never affect the map (timeline
// zero, or a timeline already present) is counted but not stored. One
// transaction in, one result transaction out. An add makes one compare
// pass for a duplicate timeline and one shift pass to insert, plus one
// more write when the marker lands in slot 0. A mapping query reads the
// RAM once per segment walked, then runs a 32-step bit-serial divide;
// with no markers accepted, timeline to source is one multiply and source
// to timeline a 64-step divide. The block holds off new input while an
// item is in work; a finished result sits in the output register so the
// next input is taken while it waits.
// Configuration may be written only while the block is idle.
`include "warp_marker_time_mapper_defines.svh"

module warp_marker_time_mapper #(
    parameter int MAX_MARKERS = wmtm_pkg::MAX_MARKERS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration write port
    input  logic                            cfg_wr,
    input  logic [wmtm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [wmtm_pkg::TIME_W-1:0]     cfg_data,
    // input channel
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [wmtm_pkg::CMD_W-1:0]      cmd,
    input  logic [wmtm_pkg::TIME_W-1:0]     marker_time_line,
    input  logic [wmtm_pkg::TIME_W-1:0]     marker_time_src,
    input  logic [wmtm_pkg::TIME_W-1:0]     query_time,
    // output channel
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [wmtm_pkg::TIME_W-1:0]     mapped_time,
    output logic [wmtm_pkg::STAT_W-1:0]     status
);
    import wmtm_pkg::*;

    localparam int CW = $clog2(MAX_MARKERS + 1);
    localparam int AW = $clog2(MAX_MARKERS);

    typedef enum logic [3:0] {
        ST_IDLE, ST_FIND, ST_SHIFT, ST_PUT0, ST_END, ST_LAST, ST_WALK,
        ST_MUL, ST_DIV_INIT, ST_DIV, ST_NM_MUL, ST_NM_FWD, ST_DONE
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [TIME_W-1:0]  clip_reg, srclen_reg;
    logic [RATIO_W-1:0] ratio_reg;

    // marker bookkeeping: cnt counts every accepted marker, len the stored ones
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] len_reg, len_next;
    logic [CW-1:0] idx_reg, idx_next;

    // captured transaction
    logic [CMD_W-1:0]  cmd_reg, cmd_next;
    logic [TIME_W-1:0] ml_reg, ml_next, ms_reg, ms_next, q_reg, q_next;

    // map walk
    point_t prev_reg, prev_next;
    point_t last_reg, last_next;
    point_t endpt_reg, endpt_next;
    logic   ep_pend_reg, ep_pend_next;

    // interpolation and divide
    logic [TIME_W-1:0]   off_reg, off_next, diff_reg, diff_next, base_reg, base_next;
    logic                neg_reg, neg_next, nm_div_reg, nm_div_next;
    logic [TIME_W-1:0]   div_reg, div_next, rem_reg, rem_next;
    logic [2*TIME_W-1:0] dq_reg, dq_next;
    logic [6:0]          step_reg, step_next;
    logic [2*TIME_W-1:0] prod_reg;

    // result
    logic [TIME_W-1:0] res_reg, res_next, mapped_reg, mapped_next;
    logic [STAT_W-1:0] stat_reg, stat_next, status_reg, status_next;
    logic              out_valid_reg, out_valid_next;

    // marker RAM
    point_t          mem [MAX_MARKERS];
    point_t          mem_q_reg;
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    point_t          mem_wdata;
    logic [AW-1:0]   rd_addr;

    logic [TIME_W-1:0] mul_a, mul_b;

    // divider step
    logic [TIME_W:0]     dv_shift, dv_sub;
    logic                dv_ge;
    logic [TIME_W-1:0]   dv_rem;
    logic [2*TIME_W-1:0] dv_dq;

    // combinational helpers
    logic              in_accept;
    logic [TIME_W-1:0] ep_src;
    point_t            last_c, nxt;
    logic              have_mem, take_ep, is_fwd;
    logic [TIME_W-1:0] span_c;
    logic [47:0]       nm_r;

    assign in_accept = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign mapped_time = mapped_reg;
    assign status      = status_reg;
    assign rd_addr     = idx_next[AW-1:0];
    assign is_fwd      = (cmd_reg == CMD_FWD);

    assign dv_shift = {rem_reg, dq_reg[2*TIME_W-1]};
    assign dv_sub   = dv_shift - {1'b0, div_reg};
    assign dv_ge    = (dv_shift >= {1'b0, div_reg});
    assign dv_rem   = dv_ge ? dv_sub[TIME_W-1:0] : dv_shift[TIME_W-1:0];
    assign dv_dq    = {dq_reg[2*TIME_W-2:0], dv_ge};

    assign nm_r = prod_reg[63:16];

    // shared multiplier operands
    always_comb
    begin
        unique case (state_reg)
            ST_END:    begin mul_a = clip_reg; mul_b = TIME_W'(ratio_reg); end
            ST_NM_MUL: begin mul_a = q_reg;    mul_b = TIME_W'(ratio_reg); end
            default:   begin mul_a = off_reg;  mul_b = diff_reg;           end
        endcase
    end

    // end point source time and last map point
    always_comb
    begin
        ep_src = (prod_reg[63:48] != '0) ? ALL_ONES : prod_reg[47:16];
        if (srclen_reg > ep_src)
        begin
            ep_src = srclen_reg;
        end
        if (len_reg == '0)
        begin
            last_c = (clip_reg == '0) ? point_t'('0) : point_t'{clip_reg, ep_src};
        end
        else if (clip_reg > mem_q_reg.tline)
        begin
            last_c = point_t'{clip_reg, ep_src};
        end
        else
        begin
            last_c = mem_q_reg;
        end
    end

    // next map point in timeline order: merge stored markers with end point
    always_comb
    begin
        have_mem = (idx_reg < len_reg);
        take_ep  = ep_pend_reg && (!have_mem || (clip_reg < mem_q_reg.tline));
        nxt      = take_ep ? endpt_reg : mem_q_reg;
        span_c   = nxt.stime - prev_reg.stime;
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        len_next       = len_reg;
        idx_next       = idx_reg;
        cmd_next       = cmd_reg;
        ml_next        = ml_reg;
        ms_next        = ms_reg;
        q_next         = q_reg;
        prev_next      = prev_reg;
        last_next      = last_reg;
        endpt_next     = endpt_reg;
        ep_pend_next   = ep_pend_reg;
        off_next       = off_reg;
        diff_next      = diff_reg;
        base_next      = base_reg;
        neg_next       = neg_reg;
        nm_div_next    = nm_div_reg;
        div_next       = div_reg;
        rem_next       = rem_reg;
        dq_next        = dq_reg;
        step_next      = step_reg;
        res_next       = res_reg;
        stat_next      = stat_reg;
        mapped_next    = mapped_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg && out_stall;
        mem_we         = 1'b0;
        mem_waddr      = idx_reg[AW-1:0];
        mem_wdata      = point_t'{ml_reg, ms_reg};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next  = cmd;
                    ml_next   = marker_time_line;
                    ms_next   = marker_time_src;
                    q_next    = query_time;
                    res_next  = '0;
                    stat_next = STAT_OK;
                    unique case (cmd)
                        CMD_CLEAR:
                        begin
                            cnt_next   = '0;
                            len_next   = '0;
                            state_next = ST_DONE;
                        end
                        CMD_ADD:
                        begin
                            if (cnt_reg == CW'(MAX_MARKERS))
                            begin
                                stat_next  = STAT_FULL;
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                cnt_next = cnt_reg + CW'(1);
                                // timeline zero is shadowed by the origin
                                if (marker_time_line == '0)
                                begin
                                    state_next = ST_DONE;
                                end
                                else if (len_reg == '0)
                                begin
                                    mem_we     = 1'b1;
                                    mem_waddr  = '0;
                                    mem_wdata  = point_t'{marker_time_line, marker_time_src};
                                    len_next   = CW'(1);
                                    state_next = ST_DONE;
                                end
                                else
                                begin
                                    idx_next   = '0;
                                    state_next = ST_FIND;
                                end
                            end
                        end
                        CMD_FWD:
                        begin
                            state_next = (cnt_reg == '0) ? ST_NM_MUL : ST_END;
                        end
                        CMD_INV:
                        begin
                            if (cnt_reg == '0)
                            begin
                                rem_next    = '0;
                                dq_next     = {16'd0, query_time, 16'd0};
                                div_next    = TIME_W'((ratio_reg < MIN_DIV_RATIO) ?
                                                      MIN_DIV_RATIO : ratio_reg);
                                step_next   = 7'd64;
                                nm_div_next = 1'b1;
                                state_next  = ST_DIV;
                            end
                            else
                            begin
                                state_next = ST_END;
                            end
                        end
                    endcase
                end
            end

            ST_FIND:
            begin
                // an earlier marker with the same timeline wins: drop
                if (mem_q_reg.tline == ml_reg)
                begin
                    state_next = ST_DONE;
                end
                else if (idx_reg == len_reg - CW'(1))
                begin
                    state_next = ST_SHIFT;
                end
                else
                begin
                    idx_next = idx_reg + CW'(1);
                end
            end

            ST_SHIFT:
            begin
                mem_we    = 1'b1;
                mem_waddr = AW'(idx_reg + CW'(1));
                if (mem_q_reg.tline > ml_reg)
                begin
                    mem_wdata = mem_q_reg;
                    if (idx_reg == '0)
                    begin
                        // every marker moved up: new one goes to slot 0
                        state_next = ST_PUT0;
                    end
                    else
                    begin
                        idx_next = idx_reg - CW'(1);
                    end
                end
                else
                begin
                    len_next   = len_reg + CW'(1);
                    state_next = ST_DONE;
                end
            end

            ST_PUT0:
            begin
                mem_we     = 1'b1;
                mem_waddr  = '0;
                len_next   = len_reg + CW'(1);
                state_next = ST_DONE;
            end

            ST_END:
            begin
                if (len_reg != '0)
                begin
                    idx_next = len_reg - CW'(1);
                end
                state_next = ST_LAST;
            end

            ST_LAST:
            begin
                endpt_next = point_t'{clip_reg, ep_src};
                last_next  = last_c;
                if (q_reg == '0)
                begin
                    res_next   = '0;
                    state_next = ST_DONE;
                end
                else if (is_fwd && (q_reg >= last_c.tline))
                begin
                    res_next   = last_c.stime;
                    state_next = ST_DONE;
                end
                else if (!is_fwd && (q_reg >= last_c.stime))
                begin
                    res_next   = last_c.tline;
                    state_next = ST_DONE;
                end
                else
                begin
                    prev_next    = '0;
                    idx_next     = '0;
                    ep_pend_next = (clip_reg != '0);
                    state_next   = ST_WALK;
                end
            end

            ST_WALK:
            begin
                if (!take_ep && !have_mem)
                begin
                    res_next   = is_fwd ? last_reg.stime : last_reg.tline;
                    state_next = ST_DONE;
                end
                else
                begin
                    if (take_ep)
                    begin
                        ep_pend_next = 1'b0;
                    end
                    else
                    begin
                        idx_next = idx_reg + CW'(1);
                        if (ep_pend_reg && (clip_reg == mem_q_reg.tline))
                        begin
                            ep_pend_next = 1'b0;
                        end
                    end
                    if (is_fwd && (q_reg >= prev_reg.tline) && (q_reg <= nxt.tline))
                    begin
                        off_next   = q_reg - prev_reg.tline;
                        neg_next   = (nxt.stime < prev_reg.stime);
                        diff_next  = (nxt.stime < prev_reg.stime) ?
                                     (prev_reg.stime - nxt.stime) : (nxt.stime - prev_reg.stime);
                        base_next  = prev_reg.stime;
                        div_next   = (nxt.tline == prev_reg.tline) ?
                                     TIME_W'(1) : (nxt.tline - prev_reg.tline);
                        state_next = ST_MUL;
                    end
                    else if (!is_fwd && (q_reg >= prev_reg.stime) && (q_reg <= nxt.stime))
                    begin
                        off_next   = q_reg - prev_reg.stime;
                        neg_next   = 1'b0;
                        diff_next  = nxt.tline - prev_reg.tline;
                        base_next  = prev_reg.tline;
                        // flat source segment divides by one
                        div_next   = (span_c == '0) ? TIME_W'(1) : span_c;
                        state_next = ST_MUL;
                    end
                    else
                    begin
                        prev_next = nxt;
                    end
                end
            end

            ST_MUL:
            begin
                state_next = ST_DIV_INIT;
            end

            ST_DIV_INIT:
            begin
                // quotient fits 32 bits, so the high half is already below the span
                rem_next    = prod_reg[63:32];
                dq_next     = {prod_reg[31:0], 32'd0};
                step_next   = 7'd32;
                nm_div_next = 1'b0;
                state_next  = ST_DIV;
            end

            ST_DIV:
            begin
                rem_next  = dv_rem;
                dq_next   = dv_dq;
                step_next = step_reg - 7'd1;
                if (step_reg == 7'd1)
                begin
                    if (nm_div_reg)
                    begin
                        if (dv_dq[63:32] != '0)
                        begin
                            res_next  = ALL_ONES;
                            stat_next = STAT_SAT;
                        end
                        else
                        begin
                            res_next = dv_dq[31:0];
                        end
                    end
                    else
                    begin
                        res_next = neg_reg ? (base_reg - dv_dq[31:0]) : (base_reg + dv_dq[31:0]);
                    end
                    state_next = ST_DONE;
                end
            end

            ST_NM_MUL:
            begin
                state_next = ST_NM_FWD;
            end

            ST_NM_FWD:
            begin
                if (nm_r[47:32] != '0)
                begin
                    res_next  = ALL_ONES;
                    stat_next = STAT_SAT;
                end
                else
                begin
                    res_next = nm_r[31:0];
                end
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    mapped_next    = res_reg;
                    status_next    = stat_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // marker RAM: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_q_reg <= mem[rd_addr];
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg   <= 64'(mul_a) * 64'(mul_b);
        cmd_reg    <= cmd_next;
        ml_reg     <= ml_next;
        ms_reg     <= ms_next;
        q_reg      <= q_next;
        prev_reg   <= prev_next;
        last_reg   <= last_next;
        endpt_reg  <= endpt_next;
        off_reg    <= off_next;
        diff_reg   <= diff_next;
        base_reg   <= base_next;
        neg_reg    <= neg_next;
        div_reg    <= div_next;
        rem_reg    <= rem_next;
        dq_reg     <= dq_next;
        res_reg    <= res_next;
        stat_reg   <= stat_next;
        mapped_reg <= mapped_next;
        status_reg <= status_next;
    end

    // control state, configuration and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            len_reg       <= '0;
            idx_reg       <= '0;
            ep_pend_reg   <= 1'b0;
            nm_div_reg    <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            clip_reg      <= '0;
            srclen_reg    <= '0;
            ratio_reg     <= RATIO_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            len_reg       <= len_next;
            idx_reg       <= idx_next;
            ep_pend_reg   <= ep_pend_next;
            nm_div_reg    <= nm_div_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr)
            begin
                unique case (cfg_index)
                    REG_CLIP:   clip_reg   <= cfg_data;
                    REG_SRCLEN: srclen_reg <= cfg_data;
                    REG_RATIO:  ratio_reg  <= cfg_data[RATIO_W-1:0];
                    default:    ;
                endcase
            end
        end
    end

    `WMTM_ASSERT_ALWAYS(a_len_le_cnt, len_reg <= cnt_reg, "stored markers exceed count")
    `WMTM_ASSERT_ALWAYS(a_cnt_max, cnt_reg <= CW'(MAX_MARKERS), "marker count above capacity")
    `WMTM_ASSERT_ALWAYS(a_div_rem, (state_reg != ST_DIV) || (rem_reg < div_reg),
                        "divider remainder not below divisor")
    `WMTM_ASSERT_NEXT(a_clear, in_accept && (cmd == CMD_CLEAR), cnt_reg == '0,
                      "clear did not empty the marker store")

endmodule
